[src/psw_pkg.sv]
package psw_pkg;

  localparam int STORED_CHARS    = 4;
  localparam int PORTS_PER_GROUP = 6;

  localparam int IDX_W   = $clog2(STORED_CHARS);
  localparam int CNT_W   = $clog2(STORED_CHARS + 1);
  localparam int STATE_W = 2 * PORTS_PER_GROUP;
  localparam int PORT_W  = $clog2(PORTS_PER_GROUP + 1);
  localparam int KIND_W  = 3;

  localparam int IN_TDATA_W = 8;

  // reply kind travels alone on tuser
  localparam int OUT_TUSER_W = KIND_W;

  // output tdata layout, lowest bit first
  localparam int OFS_STATE  = 0;
  localparam int OFS_RQ     = OFS_STATE + STATE_W;
  localparam int OFS_RG     = OFS_RQ + 1;
  localparam int OFS_RP     = OFS_RG + 1;
  localparam int OFS_SV     = OFS_RP + PORT_W;
  localparam int OUT_BITS   = OFS_SV + 1;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  localparam logic [7:0] CH_END    = 8'd35;
  localparam logic [7:0] CH_START  = 8'd58;
  localparam logic [7:0] CH_ZERO   = 8'd48;
  localparam logic [7:0] CH_HEAD   = 8'h48;  // H
  localparam logic [7:0] CH_OPEN   = 8'h4f;  // O
  localparam logic [7:0] CH_CLOSE  = 8'h43;  // C
  localparam logic [7:0] CH_REBOOT = 8'h52;  // R
  localparam logic [7:0] CH_SAVE   = 8'h53;  // S
  localparam logic [7:0] CH_QUERY  = 8'h51;  // Q
  localparam logic [7:0] CH_VER    = 8'h3f;  // ?
  localparam logic [7:0] CH_DC     = 8'h44;  // D
  localparam logic [7:0] CH_USB    = 8'h55;  // U

  typedef enum logic [KIND_W-1:0] {
    KIND_OPEN    = 3'd0,
    KIND_CLOSE   = 3'd1,
    KIND_REBOOT  = 3'd2,
    KIND_SAVE    = 3'd3,
    KIND_QUERY   = 3'd4,
    KIND_VERSION = 3'd5,
    KIND_UNKNOWN = 3'd6
  } kind_t;

  typedef struct packed {
    kind_t               reply_kind;
    logic [STATE_W-1:0]  port_state;
    logic                reboot_request;
    logic                reboot_group;
    logic [PORT_W-1:0]   reboot_port;
    logic                save_request;
  } result_t;

endpackage

[src/psw_in_reg.sv]
module psw_in_reg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [psw_pkg::IN_TDATA_W-1:0] s_tdata,
  input  logic                          take,
  output logic                          valid,
  output logic [7:0]                    rx_byte
);

  assign s_tready = !valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (s_tready) begin
      valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      rx_byte <= s_tdata[7:0];
    end
  end

endmodule

[src/psw_decode.sv]
module psw_decode (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [7:0]        rx_byte,
  output logic              res_fire,
  output psw_pkg::result_t  res
);

  logic                          frame_active, frame_active_next;
  logic [psw_pkg::CNT_W-1:0]     char_count, char_count_next;
  logic [7:0]                    command_chars [psw_pkg::STORED_CHARS];
  logic [7:0]                    command_chars_next [psw_pkg::STORED_CHARS];
  logic [psw_pkg::STATE_W-1:0]   sw_state, sw_state_next;

  logic [7:0]                    op_ch, grp_ch, dig_ch, digit;
  logic                          group_ok, port_ok, is_usb;
  logic [psw_pkg::PORT_W-1:0]    port_num;
  logic [psw_pkg::PORTS_PER_GROUP-1:0] grp_mask;
  logic [psw_pkg::STATE_W-1:0]   st_mask;

  // stored chars as seen at the end marker: the slot at the count reads zero
  assign op_ch  = (char_count == psw_pkg::CNT_W'(1)) ? 8'd0 : command_chars[1];
  assign grp_ch = (char_count == psw_pkg::CNT_W'(2)) ? 8'd0 : command_chars[2];
  assign dig_ch = (char_count == psw_pkg::CNT_W'(3)) ? 8'd0 : command_chars[3];

  assign digit    = dig_ch - psw_pkg::CH_ZERO;
  assign group_ok = (grp_ch == psw_pkg::CH_DC) || (grp_ch == psw_pkg::CH_USB);
  assign port_ok  = digit <= 8'(psw_pkg::PORTS_PER_GROUP);
  assign is_usb   = grp_ch == psw_pkg::CH_USB;
  assign port_num = digit[psw_pkg::PORT_W-1:0];

  always_comb begin
    if (port_num == '0) begin
      grp_mask = '1;
    end else begin
      grp_mask = psw_pkg::PORTS_PER_GROUP'(1) << (port_num - psw_pkg::PORT_W'(1));
    end
    if (is_usb) begin
      st_mask = {grp_mask, psw_pkg::PORTS_PER_GROUP'(0)};
    end else begin
      st_mask = {psw_pkg::PORTS_PER_GROUP'(0), grp_mask};
    end
  end

  always_comb begin
    frame_active_next  = frame_active;
    char_count_next    = char_count;
    command_chars_next = command_chars;
    sw_state_next      = sw_state;
    res_fire           = 1'b0;
    res.reply_kind     = psw_pkg::KIND_UNKNOWN;
    res.reboot_request = 1'b0;
    res.reboot_group   = 1'b0;
    res.reboot_port    = '0;
    res.save_request   = 1'b0;

    if (rx_byte == psw_pkg::CH_END) begin
      if (frame_active) begin
        frame_active_next = 1'b0;
        char_count_next   = '0;
        for (int i = 0; i < psw_pkg::STORED_CHARS; i++) begin
          command_chars_next[i] = 8'd0;
        end
        if ((char_count != '0) && (command_chars[0] == psw_pkg::CH_HEAD)) begin
          res_fire = 1'b1;
          case (op_ch)
            psw_pkg::CH_OPEN: begin
              res.reply_kind = psw_pkg::KIND_OPEN;
              if (group_ok && port_ok) begin
                sw_state_next = sw_state | st_mask;
              end
            end
            psw_pkg::CH_CLOSE: begin
              res.reply_kind = psw_pkg::KIND_CLOSE;
              if (group_ok && port_ok) begin
                sw_state_next = sw_state & ~st_mask;
              end
            end
            psw_pkg::CH_REBOOT: begin
              res.reply_kind = psw_pkg::KIND_REBOOT;
              if (group_ok && port_ok) begin
                res.reboot_request = 1'b1;
                res.reboot_group   = is_usb;
                res.reboot_port    = port_num;
              end
            end
            psw_pkg::CH_SAVE: begin
              res.reply_kind   = psw_pkg::KIND_SAVE;
              res.save_request = 1'b1;
            end
            psw_pkg::CH_QUERY: res.reply_kind = psw_pkg::KIND_QUERY;
            psw_pkg::CH_VER:   res.reply_kind = psw_pkg::KIND_VERSION;
            default:           res.reply_kind = psw_pkg::KIND_UNKNOWN;
          endcase
        end
      end
    end else begin
      if (frame_active && (char_count < psw_pkg::CNT_W'(psw_pkg::STORED_CHARS))) begin
        command_chars_next[char_count[psw_pkg::IDX_W-1:0]] = rx_byte;
        char_count_next = char_count + psw_pkg::CNT_W'(1);
      end
      // a start marker inside a frame restarts it
      if (rx_byte == psw_pkg::CH_START) begin
        frame_active_next = 1'b1;
        char_count_next   = '0;
      end
    end
    res.port_state = sw_state_next;
    res_fire = res_fire && step;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_active <= 1'b0;
      char_count   <= '0;
      sw_state     <= '1;
      for (int i = 0; i < psw_pkg::STORED_CHARS; i++) begin
        command_chars[i] <= 8'd0;
      end
    end else if (step) begin
      frame_active  <= frame_active_next;
      char_count    <= char_count_next;
      sw_state      <= sw_state_next;
      command_chars <= command_chars_next;
    end
  end

endmodule

[src/psw_out_reg.sv]
module psw_out_reg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            load,
  input  psw_pkg::result_t                res,
  output logic                            room,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [psw_pkg::OUT_TDATA_W-1:0] m_tdata,
  output logic [psw_pkg::OUT_TUSER_W-1:0] m_tuser
);

  psw_pkg::result_t held;

  assign room = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (room) begin
      m_tvalid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (room && load) begin
      held <= res;
    end
  end

  assign m_tuser = held.reply_kind;

  always_comb begin
    m_tdata = '0;
    m_tdata[psw_pkg::OFS_STATE +: psw_pkg::STATE_W] = held.port_state;
    m_tdata[psw_pkg::OFS_RQ]                        = held.reboot_request;
    m_tdata[psw_pkg::OFS_RG]                        = held.reboot_group;
    m_tdata[psw_pkg::OFS_RP +: psw_pkg::PORT_W]     = held.reboot_port;
    m_tdata[psw_pkg::OFS_SV]                        = held.save_request;
  end

endmodule

[src/port_switch_command_decoder_top.sv]
// port switch command decoder
//
// input stream: one received character per transaction on s_tdata[7:0]
// (field rx_byte). frames run from ':' to '#'; a ':' inside a frame restarts
// it. a frame closed by '#' that holds at least one char and starts with 'H'
// is decoded; every other byte gives no result.
// output stream: one reply transaction per decoded frame, kind on m_tuser.
// a '#' is taken into the input register, then decoded into the output
// register, which offers its reply on m_tdata and m_tuser.
// throughput: one byte per cycle unless stalled; the input register and the
// output register are decoupled so a new byte is taken while a reply waits.
// when the receiver holds m_tready low with a reply pending, the decode
// stage stops and s_tready drops once the input register is full.
// reset (rst, synchronous): no frame open, count and stored chars cleared,
// all twelve ports on, both stream registers empty.
module port_switch_command_decoder_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // rx_byte[7:0]
  input  logic [psw_pkg::IN_TDATA_W-1:0]  s_tdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // port_state[11:0], reboot_request[12], reboot_group[13],
  // reboot_port[16:14], save_request[17], zero fill up to bit 23
  output logic [psw_pkg::OUT_TDATA_W-1:0] m_tdata,
  // reply_kind[2:0]
  output logic [psw_pkg::OUT_TUSER_W-1:0] m_tuser
);

  logic             in_valid;
  logic [7:0]       rx_byte;
  logic             room;
  logic             step;
  logic             res_fire;
  psw_pkg::result_t res;

  // decode advances when a byte is held and the reply register can take one
  assign step = in_valid && room;

  psw_in_reg u_in (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .take     (room),
    .valid    (in_valid),
    .rx_byte  (rx_byte)
  );

  psw_decode u_dec (
    .clk      (clk),
    .rst      (rst),
    .step     (step),
    .rx_byte  (rx_byte),
    .res_fire (res_fire),
    .res      (res)
  );

  psw_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (res_fire),
    .res      (res),
    .room     (room),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

[src/psw_chk.sv]
module psw_chk (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic [psw_pkg::IN_TDATA_W-1:0]  s_tdata,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [psw_pkg::OUT_TDATA_W-1:0] m_tdata,
  input logic [psw_pkg::OUT_TUSER_W-1:0] m_tuser
);

  logic [psw_pkg::KIND_W-1:0] kind;
  assign kind = m_tuser;

  // reset empties the reply register
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("reply pending after reset");

  // a stalled reply holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("reply changed while stalled");

  // a reboot request only comes with a reboot reply
  a_reboot_kind: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[psw_pkg::OFS_RQ] |-> kind == psw_pkg::KIND_REBOOT)
    else $error("reboot request on non-reboot reply");

  // save request matches the save reply
  a_save_kind: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[psw_pkg::OFS_SV] == (kind == psw_pkg::KIND_SAVE))
    else $error("save request does not match reply kind");

  // a new reply traces back to a byte taken through the input register
  a_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
    else $error("reply without a byte two cycles before");

endmodule

bind port_switch_command_decoder_top psw_chk u_chk (.*);

[test/tb_top.sv]
module tb_top;
  import psw_pkg::*;

  logic                   clk;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata;
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic [OUT_TUSER_W-1:0] m_tuser;

  // idling switches for the two stream sides
  bit tx_idle_on;
  bit rx_stall_on;

  // shadow of the decoder state
  bit                 frame_open;
  int                 body_len;
  logic [7:0]         body_chars [STORED_CHARS];
  logic [STATE_W-1:0] switch_state;

  // replies still owed by the block, oldest first
  result_t pending_replies [$];

  int errors;
  int bytes_sent;
  int frame_bytes;
  int replies_seen;

  port_switch_command_decoder_top i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // mirror one accepted byte in the shadow state; a '#' that closes a frame
  // starting with 'H' owes exactly one reply
  function automatic void track_rx_byte(input logic [7:0] c);
    result_t            rep;
    logic [7:0]         op;
    logic [7:0]         grp;
    logic [7:0]         port;
    logic [STATE_W-1:0] mask;
    bit                 grp_ok;
    bit                 port_ok;
    bit                 usb;
    if (frame_open || c == CH_START) frame_bytes++;
    if (c != CH_END) begin
      if (frame_open && body_len < STORED_CHARS) begin
        body_chars[body_len] = c;
        body_len++;
      end
      if (c == CH_START) begin
        frame_open = 1'b1;
        body_len   = 0;
      end
      return;
    end
    // '#' outside a frame is dropped
    if (!frame_open) return;
    if (body_len < STORED_CHARS) body_chars[body_len] = 8'h00;
    frame_open = 1'b0;
    if (body_len >= 1 && body_chars[0] == CH_HEAD) begin
      op      = body_chars[1];
      grp     = body_chars[2];
      port    = body_chars[3] - CH_ZERO;  // wraps below '0'
      grp_ok  = (grp == CH_DC) || (grp == CH_USB);
      port_ok = port <= PORTS_PER_GROUP;
      usb     = (grp == CH_USB);
      rep     = '0;
      rep.reply_kind = KIND_UNKNOWN;
      if (op == CH_OPEN || op == CH_CLOSE || op == CH_REBOOT) begin
        rep.reply_kind = (op == CH_OPEN) ? KIND_OPEN :
                         (op == CH_CLOSE) ? KIND_CLOSE : KIND_REBOOT;
        if (grp_ok && port_ok) begin
          mask = (port == 0) ? STATE_W'({PORTS_PER_GROUP{1'b1}}) :
                               STATE_W'(1) << (port - 1);
          if (usb) mask = mask << PORTS_PER_GROUP;
          case (rep.reply_kind)
            KIND_OPEN: begin
              switch_state = switch_state | mask;
            end
            KIND_CLOSE: begin
              switch_state = switch_state & ~mask;
            end
            default: begin
              rep.reboot_request = 1'b1;
              rep.reboot_group   = usb;
              rep.reboot_port    = port[PORT_W-1:0];
            end
          endcase
        end
      end else if (op == CH_SAVE) begin
        rep.reply_kind   = KIND_SAVE;
        rep.save_request = 1'b1;
      end else if (op == CH_QUERY) begin
        rep.reply_kind = KIND_QUERY;
      end else if (op == CH_VER) begin
        rep.reply_kind = KIND_VERSION;
      end
      rep.port_state = switch_state;
      pending_replies.push_back(rep);
    end
    body_len = 0;
    foreach (body_chars[i]) body_chars[i] = 8'h00;
  endfunction

  // one input transaction: random idle cycles first, then hold the byte
  // until it is taken; tvalid stays high on return
  task automatic push_byte(input logic [7:0] b);
    while (tx_idle_on && $urandom_range(99) < 29) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    track_rx_byte(b);
    bytes_sent++;
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endtask

  // stop sending and let every owed reply come out, within a bound
  task automatic drain_replies();
    s_tvalid <= 1'b0;
    for (int w = 0; w < 20000 && pending_replies.size() > 0; w++) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // reply side: check each output transaction, then pick the next tready
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      replies_seen++;
      if (pending_replies.size() == 0) begin
        $error("reply with no command pending: tdata %h tuser %h", m_tdata, m_tuser);
        errors++;
      end else begin
        result_t want;
        want = pending_replies.pop_front();
        if (m_tuser != want.reply_kind) begin
          $error("reply_kind: expected %0d, got %0d",
                 want.reply_kind, m_tuser);
          errors++;
        end
        if (m_tdata[OFS_STATE +: STATE_W] != want.port_state) begin
          $error("port_state: expected %h, got %h",
                 want.port_state, m_tdata[OFS_STATE +: STATE_W]);
          errors++;
        end
        if (m_tdata[OFS_RQ] != want.reboot_request) begin
          $error("reboot_request: expected %0d, got %0d",
                 want.reboot_request, m_tdata[OFS_RQ]);
          errors++;
        end
        if (m_tdata[OFS_RG] != want.reboot_group) begin
          $error("reboot_group: expected %0d, got %0d",
                 want.reboot_group, m_tdata[OFS_RG]);
          errors++;
        end
        if (m_tdata[OFS_RP +: PORT_W] != want.reboot_port) begin
          $error("reboot_port: expected %0d, got %0d",
                 want.reboot_port, m_tdata[OFS_RP +: PORT_W]);
          errors++;
        end
        if (m_tdata[OFS_SV] != want.save_request) begin
          $error("save_request: expected %0d, got %0d",
                 want.save_request, m_tdata[OFS_SV]);
          errors++;
        end
      end
    end
    m_tready <= rx_stall_on ? ($urandom_range(99) >= 29) : 1'b1;
  end

  // every command letter, both groups, single ports and whole groups
  task automatic test_each_command();
    push_text(":HCD0#");  // all dc off
    push_text(":HCU0#");  // all usb off
    push_text(":HOD1#");
    push_text(":HOU6#");
    push_text(":HOD0#");
    push_text(":HCD6#");
    push_text(":HRU0#");
    push_text(":HRD6#");
    push_text(":HS#");
    push_text(":HQ#");
    push_text(":H?#");
    push_text(":HZ#");    // unknown letter
  endtask

  // framing corner cases and the byte extremes
  task automatic test_frame_edges();
    push_byte(8'h00);     // stray bytes outside a frame
    push_byte(8'hff);
    push_text("#");       // end marker with no frame open
    push_text(":#");      // empty frame
    push_text(":AOD1#");  // frame not led by 'H'
    push_text(":HCD1:HOD2#");   // restart mid-frame
    push_text(":HCD1:H#");      // restart leaves stale chars behind the count
    push_text(":HCU2345678#");  // over-long body, count saturates
    push_text(":HOX1#");  // bad group
    push_text(":HOD7#");  // port digit too high
    push_text(":HRD/#");  // port digit below '0'
    push_text(":H#");     // body of one char
    push_byte(CH_START);
    push_byte(8'hff);
    push_byte(8'h00);
    push_byte(CH_END);
  endtask

  // one random frame: mostly well-formed commands with random content,
  // the rest noise between frames or broken frames
  task automatic push_random_frame();
    logic [7:0] letters [9] = '{CH_OPEN, CH_CLOSE, CH_REBOOT, CH_SAVE, CH_QUERY,
                                CH_VER, CH_OPEN, CH_CLOSE, CH_REBOOT};
    logic [7:0] junk [8] = '{CH_HEAD, CH_DC, CH_USB, CH_START, CH_ZERO,
                             CH_OPEN, 8'h36, 8'h37};
    int roll;
    int n;
    roll = $urandom_range(99);
    if (roll < 78) begin
      push_byte(CH_START);
      push_byte(($urandom_range(19) == 0) ? 8'($urandom) : CH_HEAD);
      n = $urandom_range(9);
      push_byte((n < 9) ? letters[n] : 8'($urandom));
      if ($urandom_range(9) < 8) begin
        n = $urandom_range(9);
        push_byte((n < 4) ? CH_DC : (n < 8) ? CH_USB : 8'($urandom));
        if ($urandom_range(9) < 9)
          push_byte(($urandom_range(9) < 8) ? CH_ZERO + 8'($urandom_range(6)) :
                                              8'($urandom));
      end
      // occasionally an over-long body
      if ($urandom_range(9) == 0) begin
        repeat ($urandom_range(1, 4)) push_byte(8'($urandom));
      end
      push_byte(CH_END);
    end else if (roll < 88) begin
      repeat ($urandom_range(1, 6)) begin
        n = $urandom_range(9);
        push_byte((n == 0) ? CH_END : 8'($urandom));
      end
    end else begin
      push_byte(CH_START);
      repeat ($urandom_range(0, 6)) begin
        n = $urandom_range(11);
        push_byte((n < 8) ? junk[n] : 8'($urandom));
      end
      push_byte(CH_END);
    end
  endtask

  // random traffic until about n bytes have landed inside frames
  task automatic test_random_traffic(input int n);
    int target;
    target = frame_bytes + n;
    while (frame_bytes < target) push_random_frame();
  endtask

  // same traffic with both sides running flat out
  task automatic test_back_to_back(input int n);
    tx_idle_on  = 1'b0;
    rx_stall_on = 1'b0;
    test_random_traffic(n);
    tx_idle_on  = 1'b1;
    rx_stall_on = 1'b1;
  endtask

  initial begin
    rst         = 1'b1;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    m_tready    = 1'b0;
    tx_idle_on  = 1'b1;
    rx_stall_on = 1'b1;
    errors      = 0;
    frame_open  = 1'b0;
    body_len    = 0;
    foreach (body_chars[i]) body_chars[i] = 8'h00;
    switch_state = '1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_each_command();
    test_frame_edges();
    test_random_traffic(600);
    // hold the sender until the reply side has fully caught up
    drain_replies();
    test_back_to_back(250);
    test_random_traffic(400);

    drain_replies();
    if (pending_replies.size() != 0) begin
      $error("%0d replies never arrived", pending_replies.size());
      errors++;
    end
    $display("sent %0d bytes (%0d inside frames), checked %0d replies",
             bytes_sent, frame_bytes, replies_seen);
    $display("covered all command letters, framing corners, random and gap-free traffic");
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // watchdog, far beyond the slowest correct run
  initial begin
    #6000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
